>>> sv/particle_link_contact_generator_macros.svh
// Assertion macros shared by the checker of the particle link contact generator.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef PARTICLE_LINK_CONTACT_GENERATOR_MACROS_SVH
`define PARTICLE_LINK_CONTACT_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define PLCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define PLCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define PLCG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/plcg_pkg.sv
// Package of the particle link contact generator: widths, link kinds and stage records.
// It depends on nothing; the top level and its checker import it.
`default_nettype none

package plcg_pkg;

    localparam int POS_WIDTH = 24;
    localparam int ID_WIDTH  = 16;
    localparam int REST_W    = 24;
    localparam int RESTI_W   = 16;
    localparam int PEN_W     = 25;
    localparam int NORM_W    = 16;

    localparam int MAG_W     = POS_WIDTH + 1;
    localparam int SCALE_LIM = 30;
    localparam int SC_W      = (MAG_W > SCALE_LIM) ? SCALE_LIM : MAG_W;
    localparam int SH_MAX    = MAG_W - SC_W;
    localparam int SH_W      = 2;
    localparam int SQ_W      = 2 * SC_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SC_W + 1;
    localparam int DIST_W    = ROOT_W + 3;
    localparam int CMP_W     = ((DIST_W > REST_W) ? DIST_W : REST_W) + 1;
    localparam int NORM_FRAC = 14;
    localparam int Q_W       = NORM_FRAC + 1;
    localparam int DIV_W     = ROOT_W + Q_W + 1;
    localparam logic [PEN_W-1:0] PEN_MAX = '1;

    typedef enum logic [1:0] {
        OP_CABLE  = 2'd0,
        OP_ROD    = 2'd1,
        OP_ANCHOR = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic [ID_WIDTH-1:0]         first_id;
        logic [ID_WIDTH-1:0]         second_id;
        logic [REST_W-1:0]           rest;
        logic [RESTI_W-1:0]          resti;
        logic [2:0]                  neg;
        logic [SH_W-1:0]             shift;
        logic [2:0][SC_W-1:0]        sc;
    } t_side;

    typedef struct packed {
        logic                        emit;
        logic                        flip;
        logic                        movable;
        logic [ID_WIDTH-1:0]         first_id;
        logic [ID_WIDTH-1:0]         second_id;
        logic [RESTI_W-1:0]          resti;
        logic [2:0]                  neg;
        logic [ROOT_W-1:0]           root;
        logic [PEN_W-1:0]            pen;
    } t_post;

endpackage

`default_nettype wire

>>> sv/particle_link_contact_generator.sv
// Particle link contact generator: pipelined distance, root, compare and normal division.
// It depends on plcg_pkg for widths, link kinds and the records carried between stages.
//
// Usage: one link word enters on the input channel (i_valid, o_ready) and at most one
// contact word leaves on the output channel (o_valid, i_ready). Links of kind 3, cables
// that are slack and rods at exactly their length produce no contact word.
// The root takes one pipeline stage per result bit (ROOT_W stages) and each normal
// component takes one stage per quotient bit (Q_W stages).
// Throughput is one link per cycle while the receiver does not stall; valid bits travel
// beside the data in every stage.
// When the receiver stalls, the whole pipeline holds with its contents, and o_ready
// follows i_ready as long as the output register is full, so nothing is lost or repeated.
// A synchronous active-low reset clears every valid bit; data registers keep no reset.
// There is no configuration and no state carried from one link to the next.
`default_nettype none

module particle_link_contact_generator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [1:0]                           i_operation,
    input  wire logic [plcg_pkg::ID_WIDTH-1:0]        i_first_id,
    input  wire logic [plcg_pkg::ID_WIDTH-1:0]        i_second_id,
    input  wire logic signed [plcg_pkg::POS_WIDTH-1:0] i_first_x,
    input  wire logic signed [plcg_pkg::POS_WIDTH-1:0] i_first_y,
    input  wire logic signed [plcg_pkg::POS_WIDTH-1:0] i_first_z,
    input  wire logic signed [plcg_pkg::POS_WIDTH-1:0] i_second_x,
    input  wire logic signed [plcg_pkg::POS_WIDTH-1:0] i_second_y,
    input  wire logic signed [plcg_pkg::POS_WIDTH-1:0] i_second_z,
    input  wire logic [plcg_pkg::REST_W-1:0]          i_rest_length,
    input  wire logic [plcg_pkg::RESTI_W-1:0]         i_restitution,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [plcg_pkg::ID_WIDTH-1:0]             o_contact_first,
    output logic [plcg_pkg::ID_WIDTH-1:0]             o_contact_second,
    output logic                                      o_second_movable,
    output logic signed [plcg_pkg::NORM_W-1:0]        o_normal_x,
    output logic signed [plcg_pkg::NORM_W-1:0]        o_normal_y,
    output logic signed [plcg_pkg::NORM_W-1:0]        o_normal_z,
    output logic [plcg_pkg::PEN_W-1:0]                o_penetration,
    output logic [plcg_pkg::RESTI_W-1:0]              o_contact_restitution
);
    import plcg_pkg::*;

    logic en;

    logic signed [POS_WIDTH:0] n1_d [3];
    logic [2:0][MAG_W-1:0]     n1_mag;
    logic [2:0]                n1_neg;
    logic                      r1_vld;
    t_side                     r1_side;
    logic [2:0][MAG_W-1:0]     r1_mag;

    logic [MAG_W-1:0]          n2_max;
    logic [SH_W-1:0]           n2_shift;
    t_side                     n2_side;
    logic                      r2_vld;
    t_side                     r2_side;

    logic                      r3_vld;
    t_side                     r3_side;
    logic [2:0][SQ_W-1:0]      r3_sq;

    logic                      r_sq_vld  [0:ROOT_W];
    t_side                     r_sq_side [0:ROOT_W];
    logic [SUM_W-1:0]          r_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]         r_sq_root [0:ROOT_W];

    logic [DIST_W-1:0]         n_dist;
    logic [CMP_W-1:0]          n_diff_up;
    logic [CMP_W-1:0]          n_diff_dn;
    logic [CMP_W-1:0]          n_pen_raw;
    t_post                     n_post;
    logic [2:0][DIV_W-1:0]     n_rem0;

    logic                      r_dv_vld  [0:Q_W];
    t_post                     r_dv_side [0:Q_W];
    logic [2:0][DIV_W-1:0]     r_dv_rem  [0:Q_W];
    logic [2:0][Q_W-1:0]       r_dv_q    [0:Q_W];

    logic [2:0][NORM_W-1:0]    n_norm;

    logic                      r_o_valid;
    logic [ID_WIDTH-1:0]       r_o_first;
    logic [ID_WIDTH-1:0]       r_o_second;
    logic                      r_o_movable;
    logic [2:0][NORM_W-1:0]    r_o_norm;
    logic [PEN_W-1:0]          r_o_pen;
    logic [RESTI_W-1:0]        r_o_resti;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    // Stage 1: per-axis differences and magnitudes.
    always_comb begin
        n1_d[0] = {i_second_x[POS_WIDTH-1], i_second_x} - {i_first_x[POS_WIDTH-1], i_first_x};
        n1_d[1] = {i_second_y[POS_WIDTH-1], i_second_y} - {i_first_y[POS_WIDTH-1], i_first_y};
        n1_d[2] = {i_second_z[POS_WIDTH-1], i_second_z} - {i_first_z[POS_WIDTH-1], i_first_z};
        for (int c = 0; c < 3; c++) begin
            n1_neg[c] = n1_d[c][POS_WIDTH];
            n1_mag[c] = n1_neg[c] ? MAG_W'(-n1_d[c]) : MAG_W'(n1_d[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
        if (en) begin
            r1_side.op        <= t_op'(i_operation);
            r1_side.first_id  <= i_first_id;
            r1_side.second_id <= i_second_id;
            r1_side.rest      <= i_rest_length;
            r1_side.resti     <= i_restitution;
            r1_side.neg       <= n1_neg;
            r1_side.shift     <= '0;
            r1_side.sc        <= '0;
            r1_mag            <= n1_mag;
        end
    end

    // Stage 2: scale wide differences so that the squares stay in range.
    always_comb begin
        n2_max = r1_mag[0];
        if (r1_mag[1] > n2_max) begin
            n2_max = r1_mag[1];
        end
        if (r1_mag[2] > n2_max) begin
            n2_max = r1_mag[2];
        end
        n2_shift = '0;
        for (int k = 0; k < SH_MAX; k++) begin
            if ((n2_max >> (k + SC_W)) != '0) begin
                n2_shift = SH_W'(k + 1);
            end
        end
        n2_side       = r1_side;
        n2_side.shift = n2_shift;
        for (int c = 0; c < 3; c++) begin
            n2_side.sc[c] = SC_W'(r1_mag[c] >> n2_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_side <= n2_side;
        end
    end

    // Stage 3: squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_side <= r2_side;
            for (int c = 0; c < 3; c++) begin
                r3_sq[c] <= SQ_W'(r2_side.sc[c]) * SQ_W'(r2_side.sc[c]);
            end
        end
    end

    // Stage 4: sum of squares, the entry of the root pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= r3_vld;
        end
        if (en) begin
            r_sq_side[0] <= r3_side;
            r_sq_rem[0]  <= SUM_W'(r3_sq[0]) + SUM_W'(r3_sq[1]) + SUM_W'(r3_sq[2]);
            r_sq_root[0] <= '0;
        end
    end

    // Root pipeline: each stage settles one root bit, most significant first.
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        localparam int BI = ROOT_W - 1 - g;
        logic [SUM_W:0] trial;
        logic [SUM_W:0] rem_ext;

        assign trial   = ({1'b0, SUM_W'(r_sq_root[g])} << (BI + 1))
                       + ((SUM_W + 1)'(1) << (2 * BI));
        assign rem_ext = {1'b0, r_sq_rem[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[g+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[g+1] <= r_sq_vld[g];
            end
            if (en) begin
                r_sq_side[g+1] <= r_sq_side[g];
                if (rem_ext >= trial) begin
                    r_sq_rem[g+1]  <= SUM_W'(rem_ext - trial);
                    r_sq_root[g+1] <= r_sq_root[g] | (ROOT_W'(1) << BI);
                end else begin
                    r_sq_rem[g+1]  <= r_sq_rem[g];
                    r_sq_root[g+1] <= r_sq_root[g];
                end
            end
        end
    end

    // Compare against the rest length and prepare the normal dividends.
    always_comb begin
        n_dist    = DIST_W'(r_sq_root[ROOT_W]) << r_sq_side[ROOT_W].shift;
        n_diff_up = CMP_W'(n_dist) - CMP_W'(r_sq_side[ROOT_W].rest);
        n_diff_dn = CMP_W'(r_sq_side[ROOT_W].rest) - CMP_W'(n_dist);
        n_post.flip = 1'b0;
        n_post.emit = 1'b0;
        n_pen_raw   = n_diff_up;
        case (r_sq_side[ROOT_W].op)
            OP_ROD: begin
                n_post.emit = CMP_W'(n_dist) != CMP_W'(r_sq_side[ROOT_W].rest);
                if (CMP_W'(n_dist) < CMP_W'(r_sq_side[ROOT_W].rest)) begin
                    n_post.flip = 1'b1;
                    n_pen_raw   = n_diff_dn;
                end
            end
            OP_CABLE, OP_ANCHOR: begin
                n_post.emit = CMP_W'(n_dist) >= CMP_W'(r_sq_side[ROOT_W].rest);
            end
            default: begin
                n_post.emit = 1'b0;
            end
        endcase
        n_post.pen = (n_pen_raw > CMP_W'(PEN_MAX)) ? PEN_MAX : PEN_W'(n_pen_raw);
        n_post.movable   = r_sq_side[ROOT_W].op != OP_ANCHOR;
        n_post.first_id  = r_sq_side[ROOT_W].first_id;
        n_post.second_id = n_post.movable ? r_sq_side[ROOT_W].second_id : '0;
        n_post.resti     = (r_sq_side[ROOT_W].op == OP_ROD) ? '0 : r_sq_side[ROOT_W].resti;
        n_post.neg       = r_sq_side[ROOT_W].neg;
        n_post.root      = r_sq_root[ROOT_W];
        for (int c = 0; c < 3; c++) begin
            n_rem0[c] = (DIV_W'(r_sq_side[ROOT_W].sc[c]) << NORM_FRAC)
                      + DIV_W'(r_sq_root[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_sq_vld[ROOT_W];
        end
        if (en) begin
            r_dv_side[0] <= n_post;
            r_dv_rem[0]  <= n_rem0;
            r_dv_q[0]    <= '0;
        end
    end

    // Division pipeline: one quotient bit per stage for all three axes.
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        localparam int QB = Q_W - 1 - g;
        logic [DIV_W-1:0] dsh;

        assign dsh = DIV_W'(r_dv_side[g].root) << QB;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[g+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[g+1] <= r_dv_vld[g];
            end
            if (en) begin
                r_dv_side[g+1] <= r_dv_side[g];
                for (int c = 0; c < 3; c++) begin
                    if (r_dv_rem[g][c] >= dsh) begin
                        r_dv_rem[g+1][c] <= r_dv_rem[g][c] - dsh;
                        r_dv_q[g+1][c]   <= r_dv_q[g][c] | (Q_W'(1) << QB);
                    end else begin
                        r_dv_rem[g+1][c] <= r_dv_rem[g][c];
                        r_dv_q[g+1][c]   <= r_dv_q[g][c];
                    end
                end
            end
        end
    end

    // Output register: apply signs and the zero-distance case.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_dv_side[Q_W].root == '0) begin
                n_norm[c] = '0;
            end else if (r_dv_side[Q_W].neg[c] != r_dv_side[Q_W].flip) begin
                n_norm[c] = NORM_W'(0) - NORM_W'(r_dv_q[Q_W][c]);
            end else begin
                n_norm[c] = NORM_W'(r_dv_q[Q_W][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_dv_vld[Q_W] && r_dv_side[Q_W].emit;
        end
        if (en) begin
            r_o_first   <= r_dv_side[Q_W].first_id;
            r_o_second  <= r_dv_side[Q_W].second_id;
            r_o_movable <= r_dv_side[Q_W].movable;
            r_o_norm    <= n_norm;
            r_o_pen     <= r_dv_side[Q_W].pen;
            r_o_resti   <= r_dv_side[Q_W].resti;
        end
    end

    assign o_valid               = r_o_valid;
    assign o_contact_first       = r_o_first;
    assign o_contact_second      = r_o_second;
    assign o_second_movable      = r_o_movable;
    assign o_normal_x            = r_o_norm[0];
    assign o_normal_y            = r_o_norm[1];
    assign o_normal_z            = r_o_norm[2];
    assign o_penetration         = r_o_pen;
    assign o_contact_restitution = r_o_resti;

endmodule

`default_nettype wire

>>> sv/plcg_checker.sv
// Port checker of the particle link contact generator, bound to the top level.
// It depends on plcg_pkg and on the assertion macros header.
`default_nettype none

`include "particle_link_contact_generator_macros.svh"

module plcg_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  o_valid,
    input wire logic                                  i_ready,
    input wire logic [plcg_pkg::ID_WIDTH-1:0]         o_contact_second,
    input wire logic                                  o_second_movable,
    input wire logic signed [plcg_pkg::NORM_W-1:0]    o_normal_x,
    input wire logic signed [plcg_pkg::NORM_W-1:0]    o_normal_y,
    input wire logic signed [plcg_pkg::NORM_W-1:0]    o_normal_z,
    input wire logic [plcg_pkg::PEN_W-1:0]            o_penetration
);
    import plcg_pkg::*;

    localparam logic signed [NORM_W-1:0] NORM_HI = NORM_W'(16384);
    localparam logic signed [NORM_W-1:0] NORM_LO = -NORM_W'(16384);

    `PLCG_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid)
    `PLCG_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_penetration) && $stable(o_normal_x))
    `PLCG_ASSERT_NOW(a_anchor_second, i_clk, i_rst_n, o_valid && !o_second_movable, o_contact_second == '0)
    `PLCG_ASSERT_NOW(a_normal_range, i_clk, i_rst_n, o_valid, o_normal_x <= NORM_HI && o_normal_x >= NORM_LO && o_normal_y <= NORM_HI && o_normal_y >= NORM_LO && o_normal_z <= NORM_HI && o_normal_z >= NORM_LO)

endmodule

bind particle_link_contact_generator plcg_checker u_plcg_checker (.*);

`default_nettype wire

>>> sim/tb_particle_link_contact_generator.sv
// Testbench of the particle link contact generator: directed table, then random links.
// Each contact word is checked against a behavioral predictor; depends on plcg_pkg.
`default_nettype none

module tb_particle_link_contact_generator;
    import plcg_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] fid;
        logic [15:0] sid;
        logic [23:0] p1 [3];
        logic [23:0] p2 [3];
        logic [23:0] rest;
        logic [15:0] resti;
    } t_link;

    typedef struct {
        logic [15:0] first;
        logic [15:0] second;
        logic        movable;
        logic [15:0] nrm [3];
        logic [24:0] pen;
        logic [15:0] resti;
    } t_contact;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid;
    logic i_ready = 1'b0;
    logic [1:0] i_operation;
    logic [15:0] i_first_id, i_second_id;
    logic signed [23:0] i_first_x, i_first_y, i_first_z, i_second_x, i_second_y, i_second_z;
    logic [23:0] i_rest_length;
    logic [15:0] i_restitution;
    logic [15:0] o_contact_first, o_contact_second, o_contact_restitution;
    logic o_second_movable;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [24:0] o_penetration;

    particle_link_contact_generator DUT (.*);

    t_contact pending_contacts [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 0;
    bit  hold_rx = 0;
    bit  done_tx = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit predict_contact(t_link l, output t_contact c);
        longint d [3];
        longint unsigned mag [3];
        longint unsigned sum, root, pen, q;
        bit flip;
        flip = 0;
        if (l.op == OP_NONE) return 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(l.p2[i])) - longint'($signed(l.p1[i]));
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            sum += mag[i] * mag[i];
        end
        root = isqrt(sum);
        if (l.op == OP_ROD) begin
            if (root == l.rest) return 0;
            if (root > l.rest) pen = root - l.rest;
            else begin
                pen = l.rest - root;
                flip = 1;
            end
        end else begin
            if (root < l.rest) return 0;
            pen = root - l.rest;
        end
        if (pen > 25'h1FFFFFF) pen = 25'h1FFFFFF;
        c.first = l.fid;
        c.second = (l.op == OP_ANCHOR) ? 16'd0 : l.sid;
        c.movable = (l.op != OP_ANCHOR);
        for (int i = 0; i < 3; i++) begin
            if (root == 0) q = 0;
            else begin
                q = (mag[i] * 16384 + (root >> 1)) / root;
                if ((d[i] < 0) != flip) q = -q;
            end
            c.nrm[i] = q[15:0];
        end
        c.pen = pen[24:0];
        c.resti = (l.op == OP_ROD) ? 16'd0 : l.resti;
        return 1;
    endfunction

    function automatic logic [23:0] rand_pos(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 16383)) - 8192);
            default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    function automatic t_link rand_link();
        t_link l;
        int mode;
        longint unsigned s;
        mode = $urandom_range(0, 9) < 7 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0);
        l.op = 2'($urandom);
        l.fid = 16'($urandom);
        l.sid = 16'($urandom);
        l.resti = 16'($urandom);
        s = 0;
        for (int i = 0; i < 3; i++) begin
            l.p1[i] = rand_pos(mode);
            l.p2[i] = (mode == 1) ? l.p1[i] + rand_pos(1) : rand_pos(mode);
            s += (longint'($signed(l.p2[i])) - longint'($signed(l.p1[i])))
                 * (longint'($signed(l.p2[i])) - longint'($signed(l.p1[i])));
        end
        case ($urandom_range(0, 3))
            0: l.rest = 24'($urandom);
            1: l.rest = 24'(isqrt(s));
            2: l.rest = 24'(isqrt(s) + $urandom_range(0, 64) - 32);
            default: l.rest = 24'($urandom_range(0, 20000));
        endcase
        return l;
    endfunction

    task automatic send_link(t_link l);
        t_contact c;
        i_valid <= 1;
        i_operation <= l.op;
        i_first_id <= l.fid;
        i_second_id <= l.sid;
        i_first_x <= l.p1[0];
        i_first_y <= l.p1[1];
        i_first_z <= l.p1[2];
        i_second_x <= l.p2[0];
        i_second_y <= l.p2[1];
        i_second_z <= l.p2[2];
        i_rest_length <= l.rest;
        i_restitution <= l.resti;
        do @(posedge i_clk); while (!o_ready);
        if (predict_contact(l, c)) pending_contacts.push_back(c);
        if (!calm && $urandom_range(0, 99) < 23) begin
            i_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 23);
        end
    endtask

    task automatic check_contact(t_contact c);
        if (c.first !== o_contact_first || c.second !== o_contact_second ||
            c.movable !== o_second_movable || c.nrm[0] !== o_normal_x ||
            c.nrm[1] !== o_normal_y || c.nrm[2] !== o_normal_z ||
            c.pen !== o_penetration || c.resti !== o_contact_restitution) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %h %h %b %h %h %h %h %h got %h %h %b %h %h %h %h %h",
                    c.first, c.second, c.movable, c.nrm[0], c.nrm[1], c.nrm[2], c.pen,
                    c.resti, o_contact_first, o_contact_second, o_second_movable,
                    o_normal_x, o_normal_y, o_normal_z, o_penetration,
                    o_contact_restitution);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_contacts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: unexpected contact word");
            end else begin
                check_contact(pending_contacts.pop_front());
            end
        end
        i_ready <= !hold_rx && (calm || $urandom_range(0, 99) >= 23);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || hold_rx) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("FAIL particle_link_contact_generator");
                $finish;
            end
        end
    end

    initial begin
        t_link l;
        t_contact c, exp_c;
        t_link dir [$];
        i_rst_n = 0;
        i_valid = 0;
        i_operation = 0;
        i_first_id = 0;
        i_second_id = 0;
        i_first_x = 0;
        i_first_y = 0;
        i_first_z = 0;
        i_second_x = 0;
        i_second_y = 0;
        i_second_z = 0;
        i_rest_length = 0;
        i_restitution = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Zero distance cable: zero normal, penetration zero, read off directly.
        l = '{OP_CABLE, 16'hFFFF, 16'h0000, '{0, 0, 0}, '{0, 0, 0}, 24'd0, 16'hFFFF};
        exp_c = '{16'hFFFF, 16'h0000, 1'b1, '{0, 0, 0}, 25'd0, 16'hFFFF};
        void'(predict_contact(l, c));
        if (c.first !== exp_c.first || c.second !== exp_c.second ||
            c.movable !== exp_c.movable || c.nrm[0] !== exp_c.nrm[0] ||
            c.nrm[1] !== exp_c.nrm[1] || c.nrm[2] !== exp_c.nrm[2] ||
            c.pen !== exp_c.pen || c.resti !== exp_c.resti) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %h %h %b %h %h %h %h %h got %h %h %b %h %h %h %h %h",
                    exp_c.first, exp_c.second, exp_c.movable, exp_c.nrm[0], exp_c.nrm[1],
                    exp_c.nrm[2], exp_c.pen, exp_c.resti, c.first, c.second, c.movable,
                    c.nrm[0], c.nrm[1], c.nrm[2], c.pen, c.resti);
        end
        dir.push_back(l);
        // Axis aligned extremes, rods compressed and stretched, anchors, kind 3.
        dir.push_back('{OP_ROD, 16'h1234, 16'h5678, '{0, 0, 0}, '{4096, 0, 0},
                        24'hFFFFFF, 16'hAAAA});
        dir.push_back('{OP_ROD, 16'h0001, 16'h0002, '{0, 0, 0}, '{0, -4096, 0},
                        24'd4096, 16'h1111});
        dir.push_back('{OP_ROD, 16'h0003, 16'h0004, '{0, 0, 0}, '{0, 0, 8192},
                        24'd4096, 16'h1111});
        dir.push_back('{OP_ANCHOR, 16'hABCD, 16'hFFFF, '{24'h800000, 24'h800000, 24'h800000},
                        '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 24'd0, 16'h8000});
        dir.push_back('{OP_CABLE, 16'h0, 16'hFFFF, '{24'h7FFFFF, 24'h800000, 0},
                        '{24'h800000, 24'h7FFFFF, 0}, 24'hFFFFFF, 16'h0});
        dir.push_back('{OP_CABLE, 16'h7, 16'h8, '{0, 0, 0}, '{100, 200, 300},
                        24'hFFFFFF, 16'h0});
        dir.push_back('{OP_NONE, 16'h9, 16'hA, '{0, 0, 0}, '{100, 0, 0}, 24'd0, 16'h0});
        dir.push_back('{OP_ANCHOR, 16'h5, 16'h6, '{-3, 4, 0}, '{0, 0, 0}, 24'd5, 16'h7});
        dir.push_back('{OP_ROD, 16'h5, 16'h6, '{0, 0, 0}, '{0, 0, 0}, 24'd0, 16'h7});
        dir.push_back('{OP_ROD, 16'h5, 16'h6, '{0, 0, 0}, '{0, 0, 0}, 24'hFFFFFF, 16'h7});
        foreach (dir[k]) send_link(dir[k]);
        calm = 1;
        for (int n = 0; n < 300; n++) send_link(rand_link());
        calm = 0;
        hold_rx = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rx = 0;
            end
            for (int n = 0; n < 200; n++) send_link(rand_link());
        join
        i_valid <= 0;
        while (pending_contacts.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 750; n++) send_link(rand_link());
        i_valid <= 0;
        while (pending_contacts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_contacts.size() == 0) begin
            $display("PASS particle_link_contact_generator");
        end else begin
            $display("FAIL particle_link_contact_generator");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/plcg_pkg.sv
sv/particle_link_contact_generator.sv
sv/plcg_checker.sv
sim/tb_particle_link_contact_generator.sv
